FILE: rtl/agu_pkg.sv
// Shared constants and types of the activation gradient unit.
`default_nettype none

package agu_pkg;

  localparam int FRAC_BITS = 12;
  localparam int DATA_W    = 16;
  localparam int ONE       = 1 << FRAC_BITS;

  // Divider operand and quotient widths
  localparam int NUM_W = 3 * FRAC_BITS + 1;
  localparam int DEN_W = 2 * DATA_W;
  localparam int QUO_W = FRAC_BITS + 3;

  // Configuration port
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_ACTIVATION_MODE = 2'd0;

  localparam logic [1:0] MODE_SOFTSIGN = 2'd0;
  localparam logic [1:0] MODE_TANH_RES = 2'd1;

  // Sideband that travels beside the divider
  typedef struct packed {
    logic signed [DATA_W-1:0] sum;
    logic                     last;
    logic                     sat_one;
  } agu_side_t;

endpackage

`default_nettype wire

FILE: rtl/agu_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module agu_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [agu_pkg::NUM_W-1:0]  dividend_i,
  input  logic [agu_pkg::DEN_W-1:0]  divisor_i,
  input  agu_pkg::agu_side_t         side_i,
  output logic                       valid_o,
  output logic [agu_pkg::QUO_W-1:0]  quotient_o,
  output agu_pkg::agu_side_t         side_o
);
  import agu_pkg::*;

  localparam int WIDE_W = DEN_W + QUO_W;

  logic              vld_s [QUO_W];
  logic [NUM_W-1:0]  rem_s [QUO_W];
  logic [DEN_W-1:0]  dvs_s [QUO_W];
  logic [QUO_W-1:0]  quo_s [QUO_W];
  agu_side_t         side_s [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int BIT = QUO_W - 1 - k;

    logic              vld_in;
    logic [NUM_W-1:0]  rem_in;
    logic [DEN_W-1:0]  dvs_in;
    logic [QUO_W-1:0]  quo_in;
    agu_side_t         side_in;
    logic [WIDE_W-1:0] rem_w;
    logic [WIDE_W-1:0] sub_w;
    logic              take;
    logic              vld_q;
    logic [NUM_W-1:0]  rem_q;
    logic [DEN_W-1:0]  dvs_q;
    logic [QUO_W-1:0]  quo_q;
    agu_side_t         side_q;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = dividend_i;
      assign dvs_in  = divisor_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_s[k-1];
      assign rem_in  = rem_s[k-1];
      assign dvs_in  = dvs_s[k-1];
      assign quo_in  = quo_s[k-1];
      assign side_in = side_s[k-1];
    end

    assign rem_w = WIDE_W'(rem_in);
    assign sub_w = WIDE_W'(dvs_in) << BIT;
    assign take  = (rem_w >= sub_w);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= take ? NUM_W'(rem_w - sub_w) : rem_in;
        dvs_q  <= dvs_in;
        quo_q  <= quo_in | (QUO_W'(take) << BIT);
        side_q <= side_in;
      end
    end

    assign vld_s[k]  = vld_q;
    assign rem_s[k]  = rem_q;
    assign dvs_s[k]  = dvs_q;
    assign quo_s[k]  = quo_q;
    assign side_s[k] = side_q;
  end

  assign valid_o    = vld_s[QUO_W-1];
  assign quotient_o = quo_s[QUO_W-1];
  assign side_o     = side_s[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/activation_gradient_unit_top.sv
// Pipeline: 3 operand stages, 15 divider stages at one quotient bit each, and 4
// derivative and product stages lie between request acceptance and result valid.
// Throughput: one request per cycle; a stalled result holds the whole pipeline.
// Reset clears every stage valid bit and sets activation_mode to softsign.
// Top level of the activation gradient unit.
`default_nettype none

module activation_gradient_unit_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [agu_pkg::APB_AW-1:0]          paddr,
  input  logic [agu_pkg::APB_DW-1:0]          pwdata,
  output logic [agu_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [agu_pkg::DATA_W-1:0]   output_grad_i,
  input  logic signed [agu_pkg::DATA_W-1:0]   carried_grad_i,
  input  logic signed [agu_pkg::DATA_W-1:0]   pre_activation_i,
  input  logic                                last_in_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [agu_pkg::DATA_W-1:0]   pre_grad_o,
  output logic                                last_out_o
);
  import agu_pkg::*;

  localparam int A2_W  = FRAC_BITS + 4;
  localparam int AT_W  = FRAC_BITS + 2;
  localparam int TN_W  = 2 * FRAC_BITS + 8;
  localparam int TD_W  = FRAC_BITS + 7;
  localparam int T_W   = FRAC_BITS + 1;
  localparam int TT_W  = 2 * T_W;
  localparam int D_W   = FRAC_BITS + 2;
  localparam int P_W   = DATA_W + D_W;
  localparam int R_W   = P_W + 1;
  localparam int MAX_POS = (1 << (DATA_W - 1)) - 1;
  localparam int MAG_NEG = 1 << (DATA_W - 1);

  logic [1:0] mode_q;
  logic       adv;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SOFTSIGN;
    end else if (psel && penable && pwrite && (paddr == ADDR_ACTIVATION_MODE)) begin
      mode_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ACTIVATION_MODE) ? APB_DW'(mode_q) : '0;

  // Advance the whole pipeline unless a finished result is held
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- S1: gradient sum and |x| ----------------
  logic signed [DATA_W:0]   sum_w;
  logic signed [DATA_W-1:0] sum_sat_w;
  logic [DATA_W-1:0]        abs_w;

  always_comb begin
    sum_w = {output_grad_i[DATA_W-1], output_grad_i}
          + {carried_grad_i[DATA_W-1], carried_grad_i};
    if (sum_w[DATA_W] != sum_w[DATA_W-1]) begin
      sum_sat_w = sum_w[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sum_sat_w = sum_w[DATA_W-1:0];
    end
    abs_w = pre_activation_i[DATA_W-1] ? DATA_W'(~pre_activation_i + 1'b1)
                                       : DATA_W'(pre_activation_i);
  end

  logic                     s1_vld_q;
  logic signed [DATA_W-1:0] s1_sum_q;
  logic [DATA_W-1:0]        s1_abs_q;
  logic                     s1_last_q;
  logic                     s1_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sum_q  <= sum_sat_w;
      s1_abs_q  <= abs_w;
      s1_last_q <= last_in_i;
      // tanh saturates to one at or beyond three
      s1_sat_q  <= (mode_q != MODE_SOFTSIGN) &&
                   ((DATA_W+2)'(abs_w) >= (DATA_W+2)'(3 * ONE));
    end
  end

  // ---------------- S2: square ----------------
  logic [DATA_W-1:0] op_w;

  assign op_w = (mode_q == MODE_SOFTSIGN) ? (DATA_W'(ONE) + s1_abs_q) : s1_abs_q;

  logic                     s2_vld_q;
  logic [DEN_W-1:0]         s2_sq_q;
  logic signed [DATA_W-1:0] s2_sum_q;
  logic [DATA_W-1:0]        s2_abs_q;
  logic                     s2_last_q;
  logic                     s2_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sq_q   <= DEN_W'(op_w) * DEN_W'(op_w);
      s2_sum_q  <= s1_sum_q;
      s2_abs_q  <= s1_abs_q;
      s2_last_q <= s1_last_q;
      s2_sat_q  <= s1_sat_q;
    end
  end

  // ---------------- S3: divider operands ----------------
  logic [A2_W-1:0]  a2_w;
  logic [AT_W-1:0]  at_w;
  logic [TN_W-1:0]  tnum_w;
  logic [TD_W-1:0]  tden_w;
  logic [NUM_W-1:0] dvd_w;
  logic [DEN_W-1:0] dvs_w;

  always_comb begin
    a2_w   = s2_sat_q ? '0 : A2_W'(s2_sq_q >> FRAC_BITS);
    at_w   = s2_sat_q ? '0 : AT_W'(s2_abs_q);
    tnum_w = TN_W'(at_w) * (TN_W'(27 * ONE) + TN_W'(a2_w));
    tden_w = TD_W'(27 * ONE) + (TD_W'(a2_w) << 3) + TD_W'(a2_w);
    if (mode_q == MODE_SOFTSIGN) begin
      dvd_w = (NUM_W'(1) << (3 * FRAC_BITS)) + NUM_W'(s2_sq_q >> 1);
      dvs_w = s2_sq_q;
    end else begin
      dvd_w = NUM_W'(tnum_w) + NUM_W'(tden_w >> 1);
      dvs_w = DEN_W'(tden_w);
    end
  end

  logic             s3_vld_q;
  logic [NUM_W-1:0] s3_dvd_q;
  logic [DEN_W-1:0] s3_dvs_q;
  agu_side_t        s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dvd_q          <= dvd_w;
      s3_dvs_q          <= dvs_w;
      s3_side_q.sum     <= s2_sum_q;
      s3_side_q.last    <= s2_last_q;
      s3_side_q.sat_one <= s2_sat_q;
    end
  end

  // ---------------- divider ----------------
  logic             div_vld;
  logic [QUO_W-1:0] div_quo;
  agu_side_t        div_side;

  agu_divider u_agu_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (s3_vld_q),
    .dividend_i (s3_dvd_q),
    .divisor_i  (s3_dvs_q),
    .side_i     (s3_side_q),
    .valid_o    (div_vld),
    .quotient_o (div_quo),
    .side_o     (div_side)
  );

  // ---------------- P1: clamp and square t ----------------
  logic [T_W-1:0] t_w;

  always_comb begin
    if (div_side.sat_one || (div_quo > QUO_W'(ONE))) begin
      t_w = T_W'(ONE);
    end else begin
      t_w = T_W'(div_quo);
    end
  end

  logic                     p1_vld_q;
  logic [T_W-1:0]           p1_t_q;
  logic [TT_W-1:0]          p1_tt_q;
  logic signed [DATA_W-1:0] p1_sum_q;
  logic                     p1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_t_q    <= t_w;
      p1_tt_q   <= TT_W'(t_w) * TT_W'(t_w);
      p1_sum_q  <= div_side.sum;
      p1_last_q <= div_side.last;
    end
  end

  // ---------------- P2: derivative and |sum| ----------------
  logic [T_W-1:0]    t2_w;
  logic [D_W-1:0]    d_w;
  logic [DATA_W-1:0] mag_w;

  always_comb begin
    t2_w = T_W'((p1_tt_q + TT_W'(ONE / 2)) >> FRAC_BITS);
    case (mode_q)
      MODE_SOFTSIGN: d_w = D_W'(p1_t_q);
      MODE_TANH_RES: d_w = D_W'(2 * ONE) - D_W'(t2_w);
      default:       d_w = D_W'(ONE) - D_W'(t2_w);
    endcase
    mag_w = p1_sum_q[DATA_W-1] ? DATA_W'(~p1_sum_q + 1'b1) : DATA_W'(p1_sum_q);
  end

  logic              p2_vld_q;
  logic [D_W-1:0]    p2_d_q;
  logic [DATA_W-1:0] p2_mag_q;
  logic              p2_neg_q;
  logic              p2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (adv) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_d_q    <= d_w;
      p2_mag_q  <= mag_w;
      p2_neg_q  <= p1_sum_q[DATA_W-1];
      p2_last_q <= p1_last_q;
    end
  end

  // ---------------- P3: product ----------------
  logic           p3_vld_q;
  logic [P_W-1:0] p3_prod_q;
  logic           p3_neg_q;
  logic           p3_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else if (adv) begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_prod_q <= P_W'(p2_mag_q) * P_W'(p2_d_q);
      p3_neg_q  <= p2_neg_q;
      p3_last_q <= p2_last_q;
    end
  end

  // ---------------- P4: round, restore sign, saturate ----------------
  logic [R_W-1:0]           rnd_w;
  logic [DATA_W:0]          lim_w;
  logic signed [DATA_W-1:0] res_w;

  always_comb begin
    rnd_w = (R_W'(p3_prod_q) + R_W'(ONE / 2)) >> FRAC_BITS;
    if (p3_neg_q) begin
      lim_w = (rnd_w > R_W'(MAG_NEG)) ? (DATA_W+1)'(MAG_NEG) : (DATA_W+1)'(rnd_w);
      res_w = DATA_W'(~lim_w + 1'b1);
    end else begin
      lim_w = (rnd_w > R_W'(MAX_POS)) ? (DATA_W+1)'(MAX_POS) : (DATA_W+1)'(rnd_w);
      res_w = DATA_W'(lim_w);
    end
  end

  logic                     out_vld_q;
  logic signed [DATA_W-1:0] pre_grad_q;
  logic                     last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pre_grad_q <= res_w;
      last_q     <= p3_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pre_grad_o  = pre_grad_q;
  assign last_out_o  = last_q;

endmodule

`default_nettype wire

FILE: rtl/agu_checker.sv
// Port-level checks of the activation gradient unit and their binding.
`default_nettype none

module agu_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [agu_pkg::APB_AW-1:0]        paddr,
  input logic [agu_pkg::APB_DW-1:0]        pwdata,
  input logic [agu_pkg::APB_DW-1:0]        prdata,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [agu_pkg::DATA_W-1:0] pre_grad_o,
  input logic                              last_out_o
);
  import agu_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pre_grad_o) && $stable(last_out_o))
    else $error("stalled result changed");

  // Input side stalls exactly when a finished result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  // Read back the mode just written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr == ADDR_ACTIVATION_MODE) |=>
      (paddr != ADDR_ACTIVATION_MODE) ||
      ((prdata[1:0] == $past(pwdata[1:0])) && (prdata[APB_DW-1:2] == '0)))
    else $error("activation_mode readback mismatch");

endmodule

bind activation_gradient_unit_top agu_checker u_agu_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the activation gradient unit.
`timescale 1ns / 1ps

module testbench;
  import agu_pkg::*;

  localparam int GRAD_MAX = (1 << (DATA_W - 1)) - 1;
  localparam int GRAD_MIN = -(1 << (DATA_W - 1));
  localparam longint unsigned ONE_Q = ONE;
  localparam logic [1:0] MODE_TANH     = 2'd2;
  localparam logic [1:0] MODE_TANH_ALT = 2'd3;
  localparam int IDLE_SLACK        = 4;
  localparam int END_SLACK         = 40;
  localparam int LONG_STALL_CYCLES = 300;
  localparam int ITEMS_PER_MODE    = 85;
  localparam int TIMEOUT_NS        = 2_000_000;

  typedef struct packed {
    logic signed [DATA_W-1:0] pre_grad;
    logic                     last;
  } grad_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_AW-1:0]        paddr;
  logic [APB_DW-1:0]        pwdata;
  logic [APB_DW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] output_grad_i;
  logic signed [DATA_W-1:0] carried_grad_i;
  logic signed [DATA_W-1:0] pre_activation_i;
  logic                     last_in_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] pre_grad_o;
  logic                     last_out_o;

  grad_result_t pending_grads[$];
  grad_result_t next_grad;
  logic [1:0]   active_mode;
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           long_stall_left;
  bit           long_stall_arm;

  activation_gradient_unit_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .output_grad_i    (output_grad_i),
    .carried_grad_i   (carried_grad_i),
    .pre_activation_i (pre_activation_i),
    .last_in_i        (last_in_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pre_grad_o       (pre_grad_o),
    .last_out_o       (last_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gradient sum times activation derivative, rounded and saturated
  function automatic grad_result_t predict_pre_grad(input logic [1:0] mode,
      input logic signed [DATA_W-1:0] og, input logic signed [DATA_W-1:0] cg,
      input logic signed [DATA_W-1:0] pa, input logic lst);
    grad_result_t    res;
    int              sum;
    bit              neg;
    longint unsigned mag_x, deriv, tmag, tsq, a2, num, den, mag_s, prod;
    sum = int'(og) + int'(cg);
    if (sum > GRAD_MAX) sum = GRAD_MAX;
    else if (sum < GRAD_MIN) sum = GRAD_MIN;
    mag_x = (pa < 0) ? -longint'(pa) : longint'(pa);
    if (mode == MODE_SOFTSIGN) begin
      den = (ONE_Q + mag_x) * (ONE_Q + mag_x);
      num = ONE_Q * ONE_Q * ONE_Q;
      deriv = (num + den / 2) / den;
    end else begin
      if (mag_x >= 3 * ONE_Q) begin
        tmag = ONE_Q;
      end else begin
        a2 = (mag_x * mag_x) >> FRAC_BITS;
        num = mag_x * (27 * ONE_Q + a2);
        den = 27 * ONE_Q + 9 * a2;
        tmag = (num + den / 2) / den;
        if (tmag > ONE_Q) tmag = ONE_Q;
      end
      tsq = (tmag * tmag + ONE_Q / 2) >> FRAC_BITS;
      // mode three falls through to plain tanh
      deriv = (mode == MODE_TANH_RES) ? 2 * ONE_Q - tsq : ONE_Q - tsq;
    end
    neg = (sum < 0);
    mag_s = neg ? longint'(-sum) : longint'(sum);
    prod = (mag_s * deriv + ONE_Q / 2) >> FRAC_BITS;
    if (neg) begin
      if (prod > longint'(-GRAD_MIN)) prod = -GRAD_MIN;
      res.pre_grad = -prod[DATA_W-1:0];
    end else begin
      if (prod > GRAD_MAX) prod = GRAD_MAX;
      res.pre_grad = prod[DATA_W-1:0];
    end
    res.last = lst;
    return res;
  endfunction

  function automatic int rand_grad();
    case ($urandom_range(3, 0))
      0: return int'($urandom_range(2 * ONE, 0)) - ONE;
      1: return GRAD_MAX - int'($urandom_range(255, 0));
      2: return GRAD_MIN + int'($urandom_range(255, 0));
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int rand_pre_activation();
    int mag;
    case ($urandom_range(3, 0))
      0: mag = int'($urandom_range(4 * ONE, 0));
      1: mag = 3 * ONE - 4 + int'($urandom_range(8, 0));
      default: return int'($urandom);
    endcase
    return $urandom_range(1, 0) ? -mag : mag;
  endfunction

  // Receiver: random stalls, or one long hold-off when armed
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (long_stall_arm || long_stall_left != 0) begin
      if (long_stall_arm) begin
        long_stall_arm = 1'b0;
        long_stall_left = LONG_STALL_CYCLES;
      end
      out_stall_i <= 1'b1;
      long_stall_left = long_stall_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_grads.size() == 0) begin
        $display("%0t: unexpected result: expected none, got pre_grad %0d last %0b",
                 $time, pre_grad_o, last_out_o);
        mismatch_count++;
      end else begin
        next_grad = pending_grads.pop_front();
        if (pre_grad_o !== next_grad.pre_grad) begin
          $display("%0t: pre_grad mismatch: expected %0d, got %0d",
                   $time, next_grad.pre_grad, pre_grad_o);
          mismatch_count++;
        end
        if (last_out_o !== next_grad.last) begin
          $display("%0t: last_out mismatch: expected %0b, got %0b",
                   $time, next_grad.last, last_out_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_ACTIVATION_MODE) active_mode = data[1:0];
    @(posedge clk_i);
  endtask

  task automatic check_mode_readback();
    logic [APB_DW-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ACTIVATION_MODE;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[1:0] !== active_mode) begin
      $display("%0t: activation_mode readback mismatch: expected %0d, got %0d",
               $time, active_mode, rd[1:0]);
      mismatch_count++;
    end
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk_i);
    repeat (IDLE_SLACK) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] mode);
    logic [APB_DW-1:0] data;
    drain_results();
    data = $urandom;
    data[1:0] = mode;
    apb_write(ADDR_ACTIVATION_MODE, data);
    check_mode_readback();
  endtask

  task automatic send_request(input int og, input int cg, input int pa, input bit lst);
    logic signed [DATA_W-1:0] og_q, cg_q, pa_q;
    og_q = og[DATA_W-1:0];
    cg_q = cg[DATA_W-1:0];
    pa_q = pa[DATA_W-1:0];
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    output_grad_i    <= og_q;
    carried_grad_i   <= cg_q;
    pre_activation_i <= pa_q;
    last_in_i        <= lst;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_grads.push_back(predict_pre_grad(active_mode, og_q, cg_q, pa_q, lst));
  endtask

  task automatic send_random_requests(input int count);
    for (int i = 0; i < count; i++) begin
      send_request(rand_grad(), rand_grad(), rand_pre_activation(),
                   $urandom_range(7, 0) == 0);
    end
  endtask

  task automatic test_register_access();
    check_mode_readback();
    // unmapped addresses must leave the mode alone
    for (int a = 0; a < (1 << APB_AW); a++) begin
      if (a != ADDR_ACTIVATION_MODE) begin
        apb_write(a[APB_AW-1:0], $urandom);
        check_mode_readback();
      end
    end
    apb_write(ADDR_ACTIVATION_MODE, '1);
    check_mode_readback();
    apb_write(ADDR_ACTIVATION_MODE, '0);
    check_mode_readback();
  endtask

  task automatic send_edge_requests(input logic [1:0] mode);
    set_mode(mode);
    send_request(0, 0, 0, 1'b0);
    send_request(GRAD_MAX, GRAD_MAX, 0, 1'b1);
    send_request(GRAD_MIN, GRAD_MIN, GRAD_MIN, 1'b0);
    send_request(GRAD_MIN, 0, GRAD_MAX, 1'b1);
    // tanh clamp boundary and just inside it
    send_request(ONE, -1, 3 * ONE, 1'b0);
    send_request(-ONE, 1, 1 - 3 * ONE, 1'b1);
  endtask

  task automatic test_directed_edges();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_edge_requests(MODE_SOFTSIGN);
    send_edge_requests(MODE_TANH_RES);
    send_edge_requests(MODE_TANH);
    send_edge_requests(MODE_TANH_ALT);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    set_mode(MODE_SOFTSIGN);
    send_random_requests(ITEMS_PER_MODE);
    set_mode(MODE_TANH_RES);
    send_random_requests(ITEMS_PER_MODE);
    set_mode(MODE_TANH);
    send_random_requests(ITEMS_PER_MODE);
    set_mode(MODE_TANH_ALT);
    send_random_requests(ITEMS_PER_MODE);
  endtask

  // Hold the output long enough that the pipeline fills and stalls its input
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mode(MODE_TANH_RES);
    long_stall_arm = 1'b1;
    send_random_requests(60);
    drain_results();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 0;
    recv_idle_pct = 28;
    set_mode(MODE_SOFTSIGN);
    send_random_requests(20);
    drain_results();
    send_random_requests(20);
    drain_results();
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_valid_i       = 1'b0;
    output_grad_i    = '0;
    carried_grad_i   = '0;
    pre_activation_i = '0;
    last_in_i        = 1'b0;
    out_stall_i      = 1'b0;
    active_mode      = MODE_SOFTSIGN;
    mismatch_count   = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    long_stall_left  = 0;
    long_stall_arm   = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_edges();
    test_random_phase(28, 59);
    test_random_phase(59, 28);
    test_random_phase(0, 0);
    test_receiver_hold();
    test_sender_pause();

    drain_results();
    repeat (END_SLACK) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, pending_grads.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
rtl/agu_pkg.sv
rtl/agu_divider.sv
rtl/activation_gradient_unit_top.sv
rtl/agu_checker.sv
sim/testbench.sv
